>>> rtl/core/kji_pkg.sv
`default_nettype none

package kji_pkg;

   // Fixed field widths of the request and response items.
   localparam int CMD_W      = 2;
   localparam int KEY_IDX_W  = 3;
   localparam int JOINT_W    = 4;
   localparam int TIME_W     = 24;
   localparam int POS_W      = 16;
   localparam int KCOUNT_W   = 4;

   // Interpolation fraction: alpha has 16 fraction bits and may reach 1.0.
   localparam int FRAC_W     = 16;
   localparam int ALPHA_W    = FRAC_W + 1;

   typedef enum logic [CMD_W-1:0] {
      CMD_KEY_TIME = 2'd0,
      CMD_KEY_POS  = 2'd1,
      CMD_QUERY    = 2'd2
   } kji_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0]        cmd;
      logic [KEY_IDX_W-1:0]    key_index;
      logic [JOINT_W-1:0]      joint_index;
      logic [TIME_W-1:0]       key_time;
      logic signed [POS_W-1:0] key_position;
      logic [TIME_W-1:0]       query_time;
   } kji_req_type;

   typedef struct packed {
      logic [JOINT_W-1:0]      out_joint;
      logic signed [POS_W-1:0] target_position;
      logic                    last;
      logic                    ready_res;
   } kji_rsp_type;

endpackage

`default_nettype wire

>>> rtl/core/kji_req_if.sv
`default_nettype none

interface kji_req_if;
   import kji_pkg::*;

   logic        valid;
   logic        ready;
   kji_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/core/kji_rsp_if.sv
`default_nettype none

interface kji_rsp_if;
   import kji_pkg::*;

   logic        valid;
   logic        ready;
   kji_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/core/keyframe_joint_interpolator.sv
`default_nettype none

// Keyframe joint interpolator. A load request writes one keyframe time
// (unsigned Q8.16 seconds) or one joint position (signed Q4.12 radians).
// A query request returns NUM_JOINTS responses, one per joint in joint
// order, holding the target linearly interpolated between the two keyframes
// around the query time; times outside the keyframes clamp to the first or
// last key. The last flag marks the final joint and ready_res tells that the
// query time reached the last key in use. A response that is not taken holds
// the sequence until it is. The keyframe scan and the two position reads per
// joint go through single-port-read RAMs, and the blend weight comes from a
// restoring divider that settles one quotient bit per cycle. The block takes
// no new request while a query is in progress; a finished response waits in an
// output register so that the next joint can be fetched meanwhile. The key
// count register is written from csr_write_data when csr_write_enable is high.
// Key times must be written before a query reads them; the tables have no
// reset value.
module keyframe_joint_interpolator #(
   parameter int MAX_KEYS   = 8,
   parameter int NUM_JOINTS = 12
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   kji_req_if.sink                            req_bus,
   kji_rsp_if.source                          rsp_bus,
   input  wire logic                          csr_write_enable,
   input  wire logic [kji_pkg::KCOUNT_W-1:0]  csr_write_data
);

   import kji_pkg::*;

   localparam int KW       = $clog2(MAX_KEYS);
   localparam int POS_DEPTH = MAX_KEYS * NUM_JOINTS;
   localparam int PAW      = $clog2(POS_DEPTH);
   localparam int JW       = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
   localparam int REM_W    = TIME_W + 1;
   localparam int DIFF_W   = POS_W + 1;
   localparam int PROD_W   = ALPHA_W + 1 + DIFF_W;
   localparam int SUM_W    = PROD_W - FRAC_W;
   localparam int DCNT_W   = $clog2(ALPHA_W);

   // The sequencer walks through these states for a query; ST_DIV is used only when the query lies between two keys.
   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_LAST = 8'b0000_0010,
      ST_SCAN = 8'b0000_0100,
      ST_DIV  = 8'b0000_1000,
      ST_RDQ0 = 8'b0001_0000,
      ST_RDQ1 = 8'b0010_0000,
      ST_MUL  = 8'b0100_0000,
      ST_EMIT = 8'b1000_0000
   } state_type;

   state_type               state_ff, state_in;
   logic [KCOUNT_W-1:0]     key_count_ff;
   logic [TIME_W-1:0]       query_t_ff, query_t_in;
   logic [TIME_W-1:0]       last_t_ff, last_t_in;
   logic [TIME_W-1:0]       prev_t_ff, prev_t_in;
   logic                    ready_flag_ff, ready_flag_in;
   logic [KW-1:0]           idx_ff, idx_in;
   logic [KW-1:0]           lo_ff, lo_in;
   logic [KW-1:0]           hi_ff, hi_in;
   logic [ALPHA_W-1:0]      alpha_ff, alpha_in;
   logic [REM_W-1:0]        rem_ff, rem_in;
   logic [TIME_W-1:0]       den_ff, den_in;
   logic [DCNT_W-1:0]       dcnt_ff, dcnt_in;
   logic [JW-1:0]           joint_ff, joint_in;
   logic signed [POS_W-1:0] q0_ff, q0_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   kji_rsp_type             rsp_data_ff, rsp_data_in;

   logic                    req_accept;
   logic [KW-1:0]           last_idx;
   logic [KW-1:0]           time_rd_addr;
   logic [TIME_W-1:0]       time_rd_data;
   logic                    time_wr_en;
   logic [PAW-1:0]          pos_rd_addr;
   logic [POS_W-1:0]        pos_rd_data;
   logic                    pos_wr_en;
   logic [PAW-1:0]          pos_wr_addr;
   logic                    rsp_free;

   assign req_accept  = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign rsp_free    = !rsp_valid_ff || rsp_bus.ready;

   // Index of the last key in use: a count of zero acts as one key, and a
   // count above the table depth saturates.
   always_comb begin
      if (key_count_ff == '0) begin
         last_idx = '0;
      end else if (32'(key_count_ff) > MAX_KEYS) begin
         last_idx = KW'(MAX_KEYS - 1);
      end else begin
         last_idx = KW'(key_count_ff - 1'b1);
      end
   end

   // Load requests write the tables directly; indexes past the table are
   // dropped.
   assign time_wr_en = req_accept && (req_bus.payload.cmd == CMD_KEY_TIME)
                       && (32'(req_bus.payload.key_index) < MAX_KEYS);
   assign pos_wr_en  = req_accept && (req_bus.payload.cmd == CMD_KEY_POS)
                       && (32'(req_bus.payload.key_index) < MAX_KEYS)
                       && (32'(req_bus.payload.joint_index) < NUM_JOINTS);
   assign pos_wr_addr = PAW'(32'(req_bus.payload.key_index) * NUM_JOINTS
                             + 32'(req_bus.payload.joint_index));

   kji_ram #(
      .WIDTH (TIME_W),
      .DEPTH (MAX_KEYS)
   ) u_time_ram (
      .clock   (clock),
      .wr_en   (time_wr_en),
      .wr_addr (KW'(req_bus.payload.key_index)),
      .wr_data (req_bus.payload.key_time),
      .rd_addr (time_rd_addr),
      .rd_data (time_rd_data)
   );

   kji_ram #(
      .WIDTH (POS_W),
      .DEPTH (POS_DEPTH)
   ) u_pos_ram (
      .clock   (clock),
      .wr_en   (pos_wr_en),
      .wr_addr (pos_wr_addr),
      .wr_data (req_bus.payload.key_position),
      .rd_addr (pos_rd_addr),
      .rd_data (pos_rd_data)
   );

   // Sequencer. The RAMs return data in the cycle after the address, so each
   // state issues the address whose data the following state consumes.
   always_comb begin
      logic [REM_W-1:0]         rem_sub;
      logic                     qbit;
      logic signed [DIFF_W-1:0] diff;
      logic signed [ALPHA_W:0]  alpha_s;
      logic signed [SUM_W-1:0]  pos_sum;
      logic [KW-1:0]            pos_key;

      state_in      = state_ff;
      query_t_in    = query_t_ff;
      last_t_in     = last_t_ff;
      prev_t_in     = prev_t_ff;
      ready_flag_in = ready_flag_ff;
      idx_in        = idx_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      alpha_in      = alpha_ff;
      rem_in        = rem_ff;
      den_in        = den_ff;
      dcnt_in       = dcnt_ff;
      joint_in      = joint_ff;
      q0_in         = q0_ff;
      prod_in       = prod_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      time_rd_addr  = idx_ff;
      pos_key       = lo_ff;

      rem_sub = rem_ff - REM_W'(den_ff);
      qbit    = (rem_ff >= REM_W'(den_ff));
      diff    = DIFF_W'($signed(pos_rd_data)) - DIFF_W'(q0_ff);
      alpha_s = $signed({1'b0, alpha_ff});
      pos_sum = SUM_W'(q0_ff) + $signed(prod_ff[PROD_W-1:FRAC_W]);

      case (state_ff)
         ST_IDLE: begin
            time_rd_addr = last_idx;
            if (req_accept && (req_bus.payload.cmd == CMD_QUERY)) begin
               query_t_in = req_bus.payload.query_time;
               state_in   = ST_LAST;
            end
         end
         ST_LAST: begin
            last_t_in     = time_rd_data;
            ready_flag_in = (query_t_ff >= time_rd_data);
            idx_in        = '0;
            time_rd_addr  = '0;
            state_in      = ST_SCAN;
         end
         ST_SCAN: begin
            joint_in = '0;
            alpha_in = '0;
            if (idx_ff == '0) begin
               if (query_t_ff <= time_rd_data) begin
                  lo_in    = '0;
                  hi_in    = '0;
                  state_in = ST_RDQ0;
               end else if (query_t_ff >= last_t_ff) begin
                  lo_in    = last_idx;
                  hi_in    = last_idx;
                  state_in = ST_RDQ0;
               end else begin
                  prev_t_in    = time_rd_data;
                  idx_in       = idx_ff + 1'b1;
                  time_rd_addr = idx_ff + 1'b1;
               end
            end else if (query_t_ff <= time_rd_data) begin
               lo_in = idx_ff - 1'b1;
               hi_in = idx_ff;
               if ((time_rd_data > prev_t_ff) && (query_t_ff >= prev_t_ff)) begin
                  rem_in   = REM_W'(query_t_ff - prev_t_ff);
                  den_in   = time_rd_data - prev_t_ff;
                  dcnt_in  = '0;
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_RDQ0;
               end
            end else begin
               prev_t_in    = time_rd_data;
               idx_in       = idx_ff + 1'b1;
               time_rd_addr = idx_ff + 1'b1;
            end
         end
         ST_DIV: begin
            // One quotient bit per cycle, most significant first.
            alpha_in = {alpha_ff[ALPHA_W-2:0], qbit};
            if (qbit) begin
               rem_in = {rem_sub[REM_W-2:0], 1'b0};
            end else begin
               rem_in = {rem_ff[REM_W-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DCNT_W'(ALPHA_W - 1)) begin
               state_in = ST_RDQ0;
            end
         end
         ST_RDQ0: begin
            pos_key  = lo_ff;
            state_in = ST_RDQ1;
         end
         ST_RDQ1: begin
            q0_in    = $signed(pos_rd_data);
            pos_key  = hi_ff;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = alpha_s * diff;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.out_joint       = JOINT_W'(joint_ff);
               rsp_data_in.target_position = pos_sum[POS_W-1:0];
               rsp_data_in.last            = (32'(joint_ff) == NUM_JOINTS - 1);
               rsp_data_in.ready_res       = ready_flag_ff;
               if (32'(joint_ff) == NUM_JOINTS - 1) begin
                  state_in = ST_IDLE;
               end else begin
                  joint_in = joint_ff + 1'b1;
                  state_in = ST_RDQ0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      pos_rd_addr = PAW'(32'(pos_key) * NUM_JOINTS + 32'(joint_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         key_count_ff <= KCOUNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            key_count_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      query_t_ff    <= query_t_in;
      last_t_ff     <= last_t_in;
      prev_t_ff     <= prev_t_in;
      ready_flag_ff <= ready_flag_in;
      idx_ff        <= idx_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      alpha_ff      <= alpha_in;
      rem_ff        <= rem_in;
      den_ff        <= den_in;
      dcnt_ff       <= dcnt_in;
      joint_ff      <= joint_in;
      q0_ff         <= q0_in;
      prod_ff       <= prod_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_data_ff;

`ifndef SYNTHESIS
   // The partial remainder stays below twice the divisor.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < {den_ff, 1'b0}))
      else $error("divider remainder out of range");

   // The blend weight never exceeds one.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RDQ0 && alpha_ff[ALPHA_W-1]) |-> (alpha_ff[ALPHA_W-2:0] == '0))
      else $error("blend weight above one");

   // The two keys blended are the same key or neighbors.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RDQ0) |-> ((hi_ff == lo_ff) || (hi_ff == lo_ff + 1'b1)))
      else $error("blended keys are not adjacent");

   // An accepted query starts the sequence at once.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_bus.payload.cmd == CMD_QUERY) |=> (state_ff == ST_LAST))
      else $error("query did not start");
`endif

endmodule

`default_nettype wire

>>> rtl/core/kji_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module kji_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 96
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
